FILE: hdl/double_ended_priority_queue_assert.svh
// Assertion macros shared by the queue design.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DPQ_ASSERT_NOW(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DPQ_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: hdl/dpq_pkg.sv
`timescale 1ns / 1ps

package dpq_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int VALUE_W          = 32;
   localparam int OP_W             = 2;
   localparam int COUNT_OUT_W      = 7;
   localparam int STATUS_W         = 2;

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_INSERT     = 2'd0;
   localparam op_type OP_REMOVE_MAX = 2'd1;
   localparam op_type OP_REMOVE_MIN = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef logic signed [VALUE_W-1:0] value_type;

   // Command broadcast to every cell of the sorted array.
   typedef struct packed {
      logic      insert;
      logic      remove_min;
      logic      remove_max;
      value_type value;
   } cell_ctrl_type;

endpackage

FILE: hdl/dpq_req_if.sv
`timescale 1ns / 1ps

interface dpq_req_if;
   logic                 valid;
   logic                 ready;
   dpq_pkg::op_type      operation;
   dpq_pkg::value_type   value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

FILE: hdl/dpq_rsp_if.sv
`timescale 1ns / 1ps

interface dpq_rsp_if;
   logic                              valid;
   logic                              ready;
   dpq_pkg::value_type                max_value;
   dpq_pkg::value_type                min_value;
   logic [dpq_pkg::COUNT_OUT_W-1:0]   element_count;
   logic [dpq_pkg::STATUS_W-1:0]      status;

   modport source (output valid, output max_value, output min_value,
                   output element_count, output status, input ready);
   modport sink   (input valid, input max_value, input min_value,
                   input element_count, input status, output ready);
endinterface

FILE: hdl/double_ended_priority_queue.sv
`timescale 1ns / 1ps

// Double-ended priority queue of signed 32-bit values.
// The request channel carries one transaction per operation: insert a value,
// remove the largest value or remove the smallest value. The response channel
// returns one transaction per request with the maximum, the minimum, the count
// after the operation and a status: done, insert dropped because the queue is
// full, or removal ignored because the queue is empty. Both extremes read zero
// when the queue is empty. An unused operation code leaves the queue as it is.
// Storage is a row of CAPACITY cells kept in ascending order; every cell
// compares its value with the broadcast operand and shifts with its neighbors
// in the same cycle the request is taken.
// A taken request sets the stage register; in its cycle the maximum, picked
// from the top occupied cell, and the minimum are registered; the response
// valid register is set from the stage register. One transaction is in
// flight at a time, so the block accepts a new request in the cycle after
// the response is taken. While the response is stalled, it holds steady
// and no request is accepted. Synchronous reset empties the queue and drops
// any pending response.
module double_ended_priority_queue #(
   parameter int CAPACITY = dpq_pkg::DEFAULT_CAPACITY
) (
   input  logic      clock,
   input  logic      reset,
   dpq_req_if.sink   req_ch,
   dpq_rsp_if.source rsp_ch
);

   `include "double_ended_priority_queue_assert.svh"

   localparam int COUNT_W = $clog2(CAPACITY + 1);

   // Handshake and pipeline control.
   logic busy_ff, busy_in;
   logic stage_ff, stage_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_accept, rsp_accept;

   // Occupancy count.
   logic [COUNT_W-1:0] count_ff, count_in;

   // Response payload registers.
   dpq_pkg::value_type                rsp_max_ff, rsp_max_in;
   dpq_pkg::value_type                rsp_min_ff, rsp_min_in;
   logic [dpq_pkg::COUNT_OUT_W-1:0]   rsp_count_ff, rsp_count_in;
   dpq_pkg::status_type               rsp_status_ff, rsp_status_in;

   // Cell array wiring.
   dpq_pkg::cell_ctrl_type ctrl;
   dpq_pkg::value_type     cell_value [CAPACITY];
   dpq_pkg::value_type     cell_top   [CAPACITY];
   logic [CAPACITY-1:0]    cell_valid;
   logic [CAPACITY-1:0]    cell_beyond;
   logic                   full, empty;
   dpq_pkg::status_type    status;
   dpq_pkg::value_type     top_or;
   logic [COUNT_W+dpq_pkg::COUNT_OUT_W-1:0] count_ext;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign rsp_accept = rsp_ch.valid && rsp_ch.ready;
   assign full       = cell_valid[CAPACITY-1];
   assign empty      = !cell_valid[0];

   // Decode the request into the command broadcast to the cells.
   always_comb begin
      ctrl        = '0;
      ctrl.value  = req_ch.value;
      status      = dpq_pkg::STATUS_DONE;
      unique case (req_ch.operation)
         dpq_pkg::OP_INSERT: begin
            ctrl.insert = req_accept && !full;
            if (full) begin
               status = dpq_pkg::STATUS_FULL;
            end
         end
         dpq_pkg::OP_REMOVE_MAX: begin
            ctrl.remove_max = req_accept && !empty;
            if (empty) begin
               status = dpq_pkg::STATUS_EMPTY;
            end
         end
         dpq_pkg::OP_REMOVE_MIN: begin
            ctrl.remove_min = req_accept && !empty;
            if (empty) begin
               status = dpq_pkg::STATUS_EMPTY;
            end
         end
         default: begin
            status = dpq_pkg::STATUS_DONE;
         end
      endcase
   end

   // Row of sorted cells; the ends see an always-occupied slot below and an
   // empty slot above.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      dpq_pkg::value_type left_value, right_value;
      logic               left_valid, left_beyond, right_valid;

      if (i == 0) begin : g_low
         assign left_value  = '0;
         assign left_valid  = 1'b1;
         assign left_beyond = 1'b0;
      end else begin : g_mid_low
         assign left_value  = cell_value[i-1];
         assign left_valid  = cell_valid[i-1];
         assign left_beyond = cell_beyond[i-1];
      end

      if (i == CAPACITY - 1) begin : g_high
         assign right_value = cell_value[i];
         assign right_valid = 1'b0;
      end else begin : g_mid_high
         assign right_value = cell_value[i+1];
         assign right_valid = cell_valid[i+1];
      end

      dpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_value  (left_value),
         .left_valid  (left_valid),
         .left_beyond (left_beyond),
         .right_value (right_value),
         .right_valid (right_valid),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .beyond      (cell_beyond[i]),
         .top_value   (cell_top[i])
      );
   end

   // Only the highest occupied cell drives a nonzero top value, so an OR
   // across the row yields the maximum, or zero when the queue is empty.
   always_comb begin
      top_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         top_or = top_or | cell_top[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (ctrl.remove_min || ctrl.remove_max) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   assign count_ext = {{dpq_pkg::COUNT_OUT_W{1'b0}}, count_in};

   // Control: one transaction in flight from request acceptance until the
   // response is taken.
   always_comb begin
      busy_in      = busy_ff;
      stage_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         busy_in  = 1'b1;
         stage_in = 1'b1;
      end
      if (stage_ff) begin
         rsp_valid_in = 1'b1;
      end
      if (rsp_accept) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b0;
      end
   end

   // Payload: count and status are captured with the request, the extremes
   // in the next cycle from the updated cells.
   always_comb begin
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_min_in    = rsp_min_ff;
      if (req_accept) begin
         rsp_count_in  = count_ext[dpq_pkg::COUNT_OUT_W-1:0];
         rsp_status_in = status;
      end
      if (stage_ff) begin
         rsp_max_in = top_or;
         rsp_min_in = cell_valid[0] ? cell_value[0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         stage_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_min_ff    <= rsp_min_in;
   end

   assign req_ch.ready         = !busy_ff;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.max_value     = rsp_max_ff;
   assign rsp_ch.min_value     = rsp_min_ff;
   assign rsp_ch.element_count = rsp_count_ff;
   assign rsp_ch.status        = rsp_status_ff;

   // The occupied cells always match the count.
   `DPQ_ASSERT_NOW(a_count_matches_cells, clock, reset, 1'b1,
      $countones(cell_valid) == int'(count_ff), "cell occupancy differs from count")
   // A pending response blocks new requests.
   `DPQ_ASSERT_NOW(a_single_in_flight, clock, reset, rsp_ch.valid, !req_ch.ready,
      "request accepted while a response is pending")
   // The response never shows in the cycle right after acceptance.
   `DPQ_ASSERT_NEXT(a_result_stage, clock, reset, req_accept, stage_ff && !rsp_ch.valid,
      "response stage skipped")
   // A nonempty queue reports ordered extremes.
   `DPQ_ASSERT_NOW(a_extremes_ordered, clock, reset,
      rsp_ch.valid && (rsp_ch.element_count != '0),
      rsp_ch.min_value <= rsp_ch.max_value, "minimum above maximum")

endmodule

FILE: hdl/dpq_cell.sv
`timescale 1ns / 1ps

// One slot of the sorted array. Slots hold values in ascending order from
// the low end; occupied slots are contiguous starting at slot zero.
module dpq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  dpq_pkg::cell_ctrl_type ctrl,
   input  dpq_pkg::value_type    left_value,
   input  logic                  left_valid,
   input  logic                  left_beyond,
   input  dpq_pkg::value_type    right_value,
   input  logic                  right_valid,
   output dpq_pkg::value_type    value,
   output logic                  valid,
   output logic                  beyond,
   output dpq_pkg::value_type    top_value
);

   dpq_pkg::value_type value_ff, value_in;
   logic               valid_ff, valid_in;

   // This slot lies at or past the insertion point of the new value.
   assign beyond = !valid_ff || (value_ff > ctrl.value);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.insert) begin
         valid_in = left_valid;
         if (beyond) begin
            value_in = left_beyond ? left_value : ctrl.value;
         end
      end else if (ctrl.remove_min) begin
         valid_in = right_valid;
         value_in = right_value;
      end else if (ctrl.remove_max) begin
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign valid     = valid_ff;
   assign top_value = (valid_ff && !right_valid) ? value_ff : '0;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

// The testbench sends a directed table of requests, then about nine hundred
// random ones, and checks every response against its own model of the queue
// or a typed row. The model is a sorted list of signed values.
module tb_top;

   localparam int QUEUE_DEPTH = dpq_pkg::DEFAULT_CAPACITY;

   // Operation code 3 has no meaning and must leave the queue unchanged.
   localparam dpq_pkg::op_type OP_UNUSED = 2'd3;

   localparam dpq_pkg::value_type MOST_POSITIVE = 32'sh7FFF_FFFF;
   localparam dpq_pkg::value_type MOST_NEGATIVE = 32'sh8000_0000;
   localparam dpq_pkg::value_type MINUS_ONE     = 32'shFFFF_FFFF;

   localparam int DIRECTED_ROWS = 23;
   localparam int RANDOM_ITEMS  = 930;

   // Over this range of transactions neither side of the block idles.
   localparam int CALM_FIRST = 400;
   localparam int CALM_LAST  = 600;

   localparam int MAX_REPORTS = 10;

   // A row of the stimulus. When has_fixed is set, the expected response is
   // the one typed into the row; otherwise the queue model supplies it.
   typedef struct packed {
      dpq_pkg::op_type                 op;
      dpq_pkg::value_type              value;
      logic                            has_fixed;
      dpq_pkg::value_type              max_value;
      dpq_pkg::value_type              min_value;
      logic [dpq_pkg::COUNT_OUT_W-1:0] element_count;
      dpq_pkg::status_type             status;
   } request_row_type;

   typedef struct packed {
      dpq_pkg::value_type              max_value;
      dpq_pkg::value_type              min_value;
      logic [dpq_pkg::COUNT_OUT_W-1:0] element_count;
      dpq_pkg::status_type             status;
   } queue_report_type;

   logic clock;
   logic reset;

   dpq_req_if req_bus ();
   dpq_rsp_if rsp_bus ();

   double_ended_priority_queue #(
      .CAPACITY (QUEUE_DEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   request_row_type    directed_rows [DIRECTED_ROWS];
   request_row_type    request_list [$];
   dpq_pkg::value_type held_values [$];
   queue_report_type   pending_reports [$];

   int  send_index;
   int  received_count;
   int  error_count;
   bit  stimulus_done;

   // The clock starts low and rises first at 5 ns.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every block input has a known value from time zero.
   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = dpq_pkg::OP_INSERT;
      req_bus.value     = '0;
      rsp_bus.ready     = 1'b0;
   end

   // Queue model: held_values is kept in ascending signed order. A new value
   // goes after every equal value already held, so duplicates stay separate.
   function automatic queue_report_type apply_queue_op(dpq_pkg::op_type op,
                                                       dpq_pkg::value_type value);
      queue_report_type report;
      int               pos;
      report.status = dpq_pkg::STATUS_DONE;
      case (op)
         dpq_pkg::OP_INSERT: begin
            if (held_values.size() >= QUEUE_DEPTH) begin
               report.status = dpq_pkg::STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < held_values.size() && held_values[pos] <= value) pos++;
               held_values.insert(pos, value);
            end
         end
         dpq_pkg::OP_REMOVE_MAX: begin
            if (held_values.size() == 0) report.status = dpq_pkg::STATUS_EMPTY;
            else void'(held_values.pop_back());
         end
         dpq_pkg::OP_REMOVE_MIN: begin
            if (held_values.size() == 0) report.status = dpq_pkg::STATUS_EMPTY;
            else void'(held_values.pop_front());
         end
         default: begin
            // The unused code does nothing at all.
         end
      endcase
      if (held_values.size() == 0) begin
         report.max_value = '0;
         report.min_value = '0;
      end else begin
         report.max_value = held_values[held_values.size() - 1];
         report.min_value = held_values[0];
      end
      report.element_count = dpq_pkg::COUNT_OUT_W'(held_values.size());
      return report;
   endfunction

   // A random operand. Small values give plenty of duplicates, and the two
   // extremes of the signed range come up often.
   function automatic dpq_pkg::value_type pick_value();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return dpq_pkg::value_type'($urandom());
      if (roll < 70) return dpq_pkg::value_type'($signed($urandom_range(0, 15)) - 8);
      if (roll < 80) return ($urandom_range(0, 1) != 0) ? MOST_POSITIVE : MOST_NEGATIVE;
      return dpq_pkg::value_type'($signed($urandom_range(0, 2000)) - 1000);
   endfunction

   // The random part. It first fills the queue past its capacity so that
   // dropped inserts occur, then wanders between phases that fill, drain or
   // balance the queue, so that it runs full and empty several times. A few
   // transactions carry the unused code as noise.
   task automatic build_random_requests();
      request_row_type row;
      int              phase;
      int              phase_left;
      int unsigned     roll;
      row = '0;
      for (int n = 0; n < QUEUE_DEPTH + 6; n++) begin
         row.op    = dpq_pkg::OP_INSERT;
         row.value = pick_value();
         request_list = {request_list, row};
      end
      phase      = 1;
      phase_left = 0;
      for (int n = QUEUE_DEPTH + 6; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            phase      = $urandom_range(0, 2);
            phase_left = $urandom_range(30, 150);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            row.op = OP_UNUSED;
         end else begin
            roll = $urandom_range(0, 99);
            case (phase)
               0:       row.op = (roll < 70) ? dpq_pkg::OP_INSERT : dpq_pkg::OP_REMOVE_MAX;
               1:       row.op = (roll < 30) ? dpq_pkg::OP_INSERT :
                                 (roll < 65) ? dpq_pkg::OP_REMOVE_MAX :
                                 dpq_pkg::OP_REMOVE_MIN;
               default: row.op = (roll < 50) ? dpq_pkg::OP_INSERT :
                                 (roll < 75) ? dpq_pkg::OP_REMOVE_MAX :
                                 dpq_pkg::OP_REMOVE_MIN;
            endcase
            if (phase == 0 && roll >= 70 && roll < 85) row.op = dpq_pkg::OP_REMOVE_MIN;
         end
         row.value = pick_value();
         request_list = {request_list, row};
      end
   endtask

   // Main sequence: reset, stimulus, drain, verdict.
   initial begin
      directed_rows = '{
         // Removals and the unused code on an empty queue.
         '{dpq_pkg::OP_REMOVE_MIN, 32'sd0, 1'b1, 32'sd0, 32'sd0, 7'd0,
           dpq_pkg::STATUS_EMPTY},
         '{dpq_pkg::OP_REMOVE_MAX, 32'sd0, 1'b1, 32'sd0, 32'sd0, 7'd0,
           dpq_pkg::STATUS_EMPTY},
         '{OP_UNUSED, 32'sd0, 1'b1, 32'sd0, 32'sd0, 7'd0, dpq_pkg::STATUS_DONE},
         // Both ends of the signed range, zero, minus one and a duplicate.
         '{dpq_pkg::OP_INSERT, MOST_POSITIVE, 1'b1, MOST_POSITIVE, MOST_POSITIVE, 7'd1,
           dpq_pkg::STATUS_DONE},
         '{dpq_pkg::OP_INSERT, MOST_NEGATIVE, 1'b1, MOST_POSITIVE, MOST_NEGATIVE, 7'd2,
           dpq_pkg::STATUS_DONE},
         '{dpq_pkg::OP_INSERT, 32'sd0, 1'b1, MOST_POSITIVE, MOST_NEGATIVE, 7'd3,
           dpq_pkg::STATUS_DONE},
         '{dpq_pkg::OP_INSERT, MINUS_ONE, 1'b1, MOST_POSITIVE, MOST_NEGATIVE, 7'd4,
           dpq_pkg::STATUS_DONE},
         '{dpq_pkg::OP_INSERT, MOST_POSITIVE, 1'b1, MOST_POSITIVE, MOST_NEGATIVE, 7'd5,
           dpq_pkg::STATUS_DONE},
         // Removing one copy of a duplicate leaves the other one in place.
         '{dpq_pkg::OP_REMOVE_MAX, 32'sd0, 1'b1, MOST_POSITIVE, MOST_NEGATIVE, 7'd4,
           dpq_pkg::STATUS_DONE},
         '{dpq_pkg::OP_REMOVE_MAX, 32'sd0, 1'b1, 32'sd0, MOST_NEGATIVE, 7'd3,
           dpq_pkg::STATUS_DONE},
         '{dpq_pkg::OP_REMOVE_MIN, 32'sd0, 1'b1, 32'sd0, MINUS_ONE, 7'd2,
           dpq_pkg::STATUS_DONE},
         '{OP_UNUSED, 32'sh5555_AAAA, 1'b1, 32'sd0, MINUS_ONE, 7'd2,
           dpq_pkg::STATUS_DONE},
         // These rows are left to the queue model.
         '{dpq_pkg::OP_INSERT, 32'shAAAA_5555, 1'b0, 32'sd0, 32'sd0, 7'd0,
           dpq_pkg::STATUS_DONE},
         '{dpq_pkg::OP_INSERT, 32'sd1, 1'b0, 32'sd0, 32'sd0, 7'd0, dpq_pkg::STATUS_DONE},
         '{dpq_pkg::OP_INSERT, 32'sd1, 1'b0, 32'sd0, 32'sd0, 7'd0, dpq_pkg::STATUS_DONE},
         '{dpq_pkg::OP_REMOVE_MIN, 32'sd0, 1'b0, 32'sd0, 32'sd0, 7'd0,
           dpq_pkg::STATUS_DONE},
         '{dpq_pkg::OP_REMOVE_MIN, 32'sd0, 1'b0, 32'sd0, 32'sd0, 7'd0,
           dpq_pkg::STATUS_DONE},
         '{dpq_pkg::OP_REMOVE_MAX, 32'sd0, 1'b0, 32'sd0, 32'sd0, 7'd0,
           dpq_pkg::STATUS_DONE},
         '{dpq_pkg::OP_REMOVE_MAX, 32'sd0, 1'b0, 32'sd0, 32'sd0, 7'd0,
           dpq_pkg::STATUS_DONE},
         '{dpq_pkg::OP_REMOVE_MIN, 32'sd0, 1'b0, 32'sd0, 32'sd0, 7'd0,
           dpq_pkg::STATUS_DONE},
         // Back to empty, then a single value that is both extremes at once.
         '{dpq_pkg::OP_REMOVE_MAX, 32'sd0, 1'b1, 32'sd0, 32'sd0, 7'd0,
           dpq_pkg::STATUS_EMPTY},
         '{dpq_pkg::OP_INSERT, MOST_NEGATIVE, 1'b1, MOST_NEGATIVE, MOST_NEGATIVE, 7'd1,
           dpq_pkg::STATUS_DONE},
         '{dpq_pkg::OP_REMOVE_MAX, 32'sd0, 1'b1, 32'sd0, 32'sd0, 7'd0,
           dpq_pkg::STATUS_DONE}
      };
      foreach (directed_rows[i]) request_list = {request_list, directed_rows[i]};
      build_random_requests();

      // Reset is held from time zero and released on a rising edge.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (!stimulus_done || pending_reports.size() != 0) @(posedge clock);
      // An extra wait catches any response that the block should not send.
      repeat (10) @(posedge clock);

      if (error_count == 0 && pending_reports.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Request side. When a transaction completes at this edge, the queue model
   // takes the operation and stores the response it predicts. A new request
   // is presented only when the channel is free or its current transaction
   // has just completed; a stalled request is held unchanged.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            queue_report_type report;
            report = apply_queue_op(request_list[send_index].op,
                                    request_list[send_index].value);
            if (request_list[send_index].has_fixed) begin
               report.max_value     = request_list[send_index].max_value;
               report.min_value     = request_list[send_index].min_value;
               report.element_count = request_list[send_index].element_count;
               report.status        = request_list[send_index].status;
            end
            pending_reports = {pending_reports, report};
            send_index++;
            if (send_index == request_list.size()) stimulus_done = 1'b1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_index < request_list.size() &&
                ((send_index >= CALM_FIRST && send_index < CALM_LAST) ||
                 $urandom_range(0, 99) >= 20)) begin
               req_bus.valid     <= 1'b1;
               req_bus.operation <= request_list[send_index].op;
               req_bus.value     <= request_list[send_index].value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response side. Ready drops at random, and every completed transaction
   // is compared field by field with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            queue_report_type wanted;
            if (pending_reports.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("unexpected response: max %0d min %0d count %0d status %0d",
                           rsp_bus.max_value, rsp_bus.min_value,
                           rsp_bus.element_count, rsp_bus.status);
               end
            end else begin
               wanted = pending_reports.pop_front();
               if (rsp_bus.max_value !== wanted.max_value ||
                   rsp_bus.min_value !== wanted.min_value ||
                   rsp_bus.element_count !== wanted.element_count ||
                   rsp_bus.status !== wanted.status) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("response %0d: expected max %0d min %0d count %0d status %0d",
                              received_count, wanted.max_value, wanted.min_value,
                              wanted.element_count, wanted.status);
                     $display("response %0d: actual   max %0d min %0d count %0d status %0d",
                              received_count, rsp_bus.max_value, rsp_bus.min_value,
                              rsp_bus.element_count, rsp_bus.status);
                  end
               end
            end
            received_count++;
         end
         rsp_bus.ready <= (received_count >= CALM_FIRST && received_count < CALM_LAST) ||
                          ($urandom_range(0, 99) >= 20);
      end
   end

   // Watchdog: a run that has not finished by this time ends in a fail.
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/dpq_pkg.sv
hdl/dpq_req_if.sv
hdl/dpq_rsp_if.sv
hdl/dpq_cell.sv
hdl/double_ended_priority_queue.sv
tb/tb_top.sv
